// ----- rtl/tilp_pkg.sv -----
// Shared types and constants for the integer literal parser.
// Holds parse phases, base and status codes and the character classifier result.
// No dependencies.
package tilp_pkg;

    // Character codes used by the parser
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_UC_O  = 8'h4F;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_UC_B  = 8'h42;

    // Stream widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int USER_W  = 3;

    typedef enum logic [2:0] {
        PH_FIRST    = 3'd0,
        PH_SIGNED   = 3'd1,
        PH_ZERO     = 3'd2,
        PH_DEC      = 3'd3,
        PH_PREFIXED = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIGIT = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // Classification of one character against the current base
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_under;
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_prefix;
        t_base      prefix_base;
    } t_char_info;

    // Token state after its last character
    typedef struct packed {
        logic                 neg;
        t_base                base;
        t_status              err;
        logic [VALUE_W-1:0]   acc;
    } t_final;

endpackage

// ----- rtl/tilp_digit.sv -----
// Character classifier: digit value and validity for a base, sign, underscore
// and prefix letters. Depends on tilp_pkg.
module tilp_digit (
    input  logic [7:0]          i_char,
    input  tilp_pkg::t_base     i_base,
    output tilp_pkg::t_char_info o_info
);
    import tilp_pkg::*;

    logic is_dec;
    logic is_lc_hex;
    logic is_uc_hex;

    // Classify the character ranges
    assign is_dec    = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_lc_hex = (i_char >= CH_LC_A) && (i_char <= CH_LC_F);
    assign is_uc_hex = (i_char >= CH_UC_A) && (i_char <= CH_UC_F);

    // Digit value and validity for the active base
    always_comb begin
        o_info = '0;
        o_info.is_under = (i_char == CH_UNDER);
        o_info.is_plus  = (i_char == CH_PLUS);
        o_info.is_minus = (i_char == CH_MINUS);
        o_info.is_zero  = (i_char == CH_ZERO);
        o_info.digit    = (is_lc_hex || is_uc_hex) ? i_char[3:0] + 4'd9 : i_char[3:0];
        case (i_base)
            BASE_HEX: o_info.is_digit = is_dec || is_lc_hex || is_uc_hex;
            BASE_OCT: o_info.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);
            BASE_BIN: o_info.is_digit = (i_char == CH_ZERO) || (i_char == CH_ONE);
            default:  o_info.is_digit = is_dec;
        endcase
        // Prefix letter after a leading zero
        if (i_char == CH_LC_X || i_char == CH_UC_X) begin
            o_info.is_prefix   = 1'b1;
            o_info.prefix_base = BASE_HEX;
        end else if (i_char == CH_LC_O || i_char == CH_UC_O) begin
            o_info.is_prefix   = 1'b1;
            o_info.prefix_base = BASE_OCT;
        end else if (i_char == CH_LC_B || i_char == CH_UC_B) begin
            o_info.is_prefix   = 1'b1;
            o_info.prefix_base = BASE_BIN;
        end else begin
            o_info.is_prefix   = 1'b0;
            o_info.prefix_base = BASE_DEC;
        end
    end

endmodule

// ----- rtl/tilp_accum.sv -----
// Token state machine and 64-bit accumulator: one character per cycle while i_proc is high.
// Depends on tilp_pkg and tilp_digit.
module tilp_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_proc,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    output tilp_pkg::t_final     o_fin
);
    import tilp_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    t_base              r_base, n_base;
    logic [VALUE_W-1:0] r_acc, n_acc;
    t_status            r_err, n_err;

    t_char_info         info;
    logic               take;
    logic [VALUE_W+3:0] dec_sum;
    logic [VALUE_W-1:0] acc_step;
    logic               acc_ovf;

    tilp_digit u_digit (
        .i_char (i_char),
        .i_base (r_base),
        .o_info (info)
    );

    // Shift-add of one digit and overflow past 64 bits
    always_comb begin
        dec_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                + {{VALUE_W{1'b0}}, info.digit};
        case (r_base)
            BASE_HEX: begin
                acc_step = {r_acc[VALUE_W-5:0], info.digit};
                acc_ovf  = |r_acc[VALUE_W-1:VALUE_W-4];
            end
            BASE_OCT: begin
                acc_step = {r_acc[VALUE_W-4:0], info.digit[2:0]};
                acc_ovf  = |r_acc[VALUE_W-1:VALUE_W-3];
            end
            BASE_BIN: begin
                acc_step = {r_acc[VALUE_W-2:0], info.digit[0]};
                acc_ovf  = r_acc[VALUE_W-1];
            end
            default: begin
                acc_step = dec_sum[VALUE_W-1:0];
                acc_ovf  = |dec_sum[VALUE_W+3:VALUE_W];
            end
        endcase
    end

    // Next phase, sign and base
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_base  = r_base;
        take    = 1'b0;
        case (r_phase)
            PH_FIRST: begin
                if (info.is_plus || info.is_minus) begin
                    n_neg   = info.is_minus;
                    n_phase = PH_SIGNED;
                end else if (info.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = PH_DEC;
                    take    = 1'b1;
                end
            end
            PH_SIGNED: begin
                if (info.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = PH_DEC;
                    take    = 1'b1;
                end
            end
            PH_ZERO: begin
                if (info.is_prefix) begin
                    n_base  = info.prefix_base;
                    n_phase = PH_PREFIXED;
                end else begin
                    n_phase = PH_DEC;
                    take    = 1'b1;
                end
            end
            default: take = 1'b1;
        endcase
    end

    // Digit intake: invalid digit wins, overflow latches, then value frozen
    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (take && !info.is_under) begin
            if (!info.is_digit) begin
                n_err = ST_DIGIT;
            end else if (r_err == ST_OK) begin
                if (acc_ovf) begin
                    n_err = ST_OVER;
                end else begin
                    n_acc = acc_step;
                end
            end
        end
    end

    assign o_fin = '{neg: n_neg, base: n_base, err: n_err, acc: n_acc};

    // Advance on each request; return to the start after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_neg   <= 1'b0;
            r_base  <= BASE_DEC;
            r_acc   <= '0;
            r_err   <= ST_OK;
        end else if (i_proc) begin
            if (i_last) begin
                r_phase <= PH_FIRST;
                r_neg   <= 1'b0;
                r_base  <= BASE_DEC;
                r_acc   <= '0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_err   <= n_err;
            end
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && i_last) |=> (r_phase == PH_FIRST && r_acc == '0 && !r_neg))
        else $error("token state not cleared after last character");

    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_acc == '0 && r_err == ST_OK && r_base == BASE_DEC))
        else $error("start phase with leftover token state");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && !i_last && r_err != ST_OK) |=> (r_err != ST_OK))
        else $error("latched error lost within a token");

endmodule

// ----- rtl/tilp_result.sv -----
// Final-state register, result formatting (sign, kind, status) and output register.
// Depends on tilp_pkg.
module tilp_result (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  tilp_pkg::t_final            i_fin,
    output logic                        o_fin_free,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [tilp_pkg::VALUE_W-1:0] o_m_tdata,
    output logic [tilp_pkg::USER_W-1:0]  o_m_tuser
);
    import tilp_pkg::*;

    t_final             r_fin;
    logic               r_fin_valid;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_uns;
    t_status            r_out_status;

    logic               out_free;
    logic [VALUE_W-1:0] n_value;
    logic               n_uns;
    t_status            n_status;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_fin_free = !r_fin_valid || out_free;

    // Format value, kind and status from the final token state
    always_comb begin
        n_value  = '0;
        n_uns    = 1'b0;
        n_status = ST_OK;
        if (r_fin.err != ST_OK) begin
            n_status = r_fin.err;
        end else if (r_fin.neg) begin
            if (r_fin.acc[VALUE_W-1] && (|r_fin.acc[VALUE_W-2:0])) begin
                n_status = ST_RANGE;
            end else begin
                n_value = '0 - r_fin.acc;
            end
        end else begin
            n_value = r_fin.acc;
            n_uns   = (r_fin.base == BASE_HEX) || r_fin.acc[VALUE_W-1];
        end
    end

    // Hold the final state until the output stage frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_load) begin
            r_fin_valid <= 1'b1;
        end else if (out_free) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fin <= i_fin;
        end
    end

    // Output register: advance when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_value  <= n_value;
            r_out_uns    <= n_uns;
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = {r_out_status, r_out_uns};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_value == '0 && !r_out_uns))
        else $error("error result carries a value");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !out_free) |=> (r_fin_valid && $stable(r_fin)))
        else $error("pending final state lost under stall");

    a_neg_signed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && out_free && r_fin.neg) |=> !r_out_uns)
        else $error("negative result marked unsigned");

endmodule

// ----- rtl/toml_integer_literal_parser.sv -----
// Top level of the integer literal parser: input register, token accumulator
// and result stage. Depends on tilp_pkg, tilp_accum and tilp_result.
//
// Usage:
//   The slave channel carries one character of an integer token per request:
//   s_axis_tdata is the byte, s_axis_tlast marks the token's final character.
//   Leading '+'/'-', a 0x/0o/0b prefix in either case and '_' separators are
//   handled; anything else not valid for the base flags an invalid digit.
//   The master channel gives one result per token: m_axis_tdata is the 64-bit
//   value (two's complement when signed), m_axis_tuser holds is_unsigned and
//   the status (ok, invalid digit, negative out of range, overflow).
//   Throughput: one character per cycle, as the accumulator's shift-add is
//   combinational; a last character may wait for the final-state register.
//   After the edge that accepts the last character, the result is registered
//   in the final-state register and then in the output register.
//   Reset clears the token state and empties every stage.
//   When the receiver stalls, the result and one more finished token are
//   held; characters that are not last keep flowing, and a last character
//   waits in the input register until the final-state register frees.
module toml_integer_literal_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [tilp_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] char_code
    input  logic                         s_axis_tlast,  // last_char
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [tilp_pkg::VALUE_W-1:0] m_axis_tdata,  // [63:0] value_bits
    output logic [tilp_pkg::USER_W-1:0]  m_axis_tuser   // [0] is_unsigned, [2:1] status
);
    import tilp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    logic              proc;
    logic              fin_free;
    t_final            fin;

    // Process the held character; a last one needs room in the result stage
    assign proc          = r_in_valid && (!r_in_last || fin_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    tilp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_fin   (fin)
    );

    tilp_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc && r_in_last),
        .i_fin      (fin),
        .o_fin_free (fin_free),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

// ----- verif/tb_toml_integer_literal_parser.sv -----
// Self-checking testbench for toml_integer_literal_parser: streams integer tokens one
// character per request and compares each result against an in-bench parser.
// Depends on tilp_pkg and the toml_integer_literal_parser RTL.
module tb_toml_integer_literal_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import tilp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_LC_G  = 8'h67;

    typedef struct {
        logic [63:0] value;
        logic        is_uns;
        t_status     status;
    } t_int_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // [7:0] char_code
    logic         s_axis_tlast = 1'b0; // last_char
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;        // [63:0] value_bits
    logic [2:0]   m_axis_tuser;        // [0] is_unsigned, [2:1] status

    // Token state of the in-bench parser
    t_phase       tok_phase = PH_FIRST;
    logic         tok_neg = 1'b0;
    t_base        tok_base = BASE_DEC;
    logic [63:0]  tok_acc = '0;
    t_status      tok_err = ST_OK;

    t_int_result  pending_results[$];
    logic [7:0]   token_q[$];
    int           mismatch_count = 0;
    bit           idle_en = 1'b1;
    bit           hold_req = 1'b0;

    toml_integer_literal_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Digit value of a character in the given base, -1 when not a digit
    function automatic int digit_value(logic [7:0] c, t_base b);
        case (b)
            BASE_HEX: begin
                if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
                if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
                if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
                return -1;
            end
            BASE_OCT: return (c >= CH_ZERO && c <= CH_SEVEN) ? int'(c - CH_ZERO) : -1;
            BASE_BIN: return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
            default:  return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
        endcase
    endfunction

    // Fold one body character into the magnitude; skip separators, latch errors
    function automatic void accumulate(logic [7:0] c);
        int d;
        int k;
        logic [63:0] ud;
        if (c == CH_UNDER) return;
        d = digit_value(c, tok_base);
        if (d < 0) begin
            tok_err = ST_DIGIT;
            return;
        end
        if (tok_err != ST_OK) return;
        ud = 64'(d);
        if (tok_base == BASE_DEC) begin
            if (tok_acc > (64'hFFFF_FFFF_FFFF_FFFF - ud) / 64'd10) begin
                tok_err = ST_OVER;
                return;
            end
            tok_acc = tok_acc * 64'd10 + ud;
        end else begin
            k = (tok_base == BASE_HEX) ? 4 : (tok_base == BASE_OCT) ? 3 : 1;
            if ((tok_acc >> (64 - k)) != 64'd0) begin
                tok_err = ST_OVER;
                return;
            end
            tok_acc = (tok_acc << k) | ud;
        end
    endfunction

    // Advance the token parser by one character; return 1 with the result on the last one
    function automatic bit parse_char(logic [7:0] c, bit last, output t_int_result r);
        case (tok_phase)
            PH_FIRST, PH_SIGNED: begin
                if (tok_phase == PH_FIRST && (c == CH_PLUS || c == CH_MINUS)) begin
                    tok_neg = (c == CH_MINUS);
                    tok_phase = PH_SIGNED;
                end else if (c == CH_ZERO) begin
                    tok_phase = PH_ZERO;
                end else begin
                    tok_phase = PH_DEC;
                    accumulate(c);
                end
            end
            PH_ZERO: begin
                tok_phase = PH_PREFIXED;
                if (c == CH_LC_X || c == CH_UC_X) tok_base = BASE_HEX;
                else if (c == CH_LC_O || c == CH_UC_O) tok_base = BASE_OCT;
                else if (c == CH_LC_B || c == CH_UC_B) tok_base = BASE_BIN;
                else begin
                    tok_phase = PH_DEC;
                    accumulate(c);
                end
            end
            default: accumulate(c);
        endcase
        r = '{value: 64'd0, is_uns: 1'b0, status: ST_OK};
        if (!last) return 1'b0;
        if (tok_err != ST_OK) begin
            r.status = tok_err;
        end else if (tok_neg) begin
            // Magnitude 2^63 still fits as the most negative value
            if (tok_acc > 64'h8000_0000_0000_0000) r.status = ST_RANGE;
            else r.value = 64'd0 - tok_acc;
        end else begin
            r.value = tok_acc;
            r.is_uns = (tok_base == BASE_HEX) || (tok_acc > 64'h7FFF_FFFF_FFFF_FFFF);
        end
        tok_phase = PH_FIRST;
        tok_neg = 1'b0;
        tok_base = BASE_DEC;
        tok_acc = '0;
        tok_err = ST_OK;
        return 1'b1;
    endfunction

    // Offer one character, hold it until accepted, then predict
    task automatic send_char(logic [7:0] c, bit last);
        t_int_result r;
        while (idle_en && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (parse_char(c, last, r)) pending_results = {pending_results, r};
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Drop the request and wait until every predicted result has come back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(15))
            0:  return CH_PLUS;
            1:  return CH_MINUS;
            2:  return CH_ZERO;
            3:  return CH_ONE;
            4:  return CH_SEVEN;
            5:  return CH_EIGHT;
            6:  return CH_NINE;
            7:  return CH_UNDER;
            8:  return CH_LC_X;
            9:  return CH_UC_X;
            10: return CH_LC_O;
            11: return CH_UC_O;
            12: return CH_LC_B;
            13: return CH_UC_B;
            14: return CH_LC_F;
            default: return CH_LC_G;
        endcase
    endfunction

    // Magnitudes biased toward the signed and unsigned 64-bit limits
    function automatic logic [63:0] pick_magnitude();
        case ($urandom_range(3))
            0: return 64'($urandom_range(999));
            1: return {$urandom, $urandom} >> $urandom_range(63);
            2: return 64'h8000_0000_0000_0000 + 64'($urandom_range(6)) - 64'd3;
            default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
        endcase
    endfunction

    // Append the digits of v in base b, with the odd separator between digits
    function automatic void push_number(logic [63:0] v, t_base b, bit upper);
        logic [7:0] digs[$];
        logic [3:0] d;
        do begin
            case (b)
                BASE_HEX: begin d = v[3:0]; v = v >> 4; end
                BASE_OCT: begin d = {1'b0, v[2:0]}; v = v >> 3; end
                BASE_BIN: begin d = {3'b0, v[0]}; v = v >> 1; end
                default:  begin d = 4'(v % 64'd10); v = v / 64'd10; end
            endcase
            if (d < 4'd10) digs.push_front(8'(CH_ZERO + d));
            else digs.push_front(8'((upper ? CH_UC_A : CH_LC_A) + d - 8'd10));
            if (v != 64'd0 && $urandom_range(99) < 8) digs.push_front(CH_UNDER);
        end while (v != 64'd0);
        foreach (digs[i]) token_q = {token_q, digs[i]};
    endfunction

    // Build one token: mostly well-formed literals, some short symbol mixes, some raw bytes
    function automatic void build_token();
        int kind;
        t_base b;
        bit upper;
        kind = $urandom_range(99);
        upper = 1'($urandom_range(1));
        token_q.delete();
        if (kind < 75) begin
            case ($urandom_range(2))
                1: token_q = {token_q, CH_PLUS};
                2: token_q = {token_q, CH_MINUS};
                default: ;
            endcase
            b = t_base'($urandom_range(3));
            if (b != BASE_DEC) begin
                token_q = {token_q, CH_ZERO};
                case (b)
                    BASE_HEX: token_q = {token_q, $urandom_range(1) ? CH_UC_X : CH_LC_X};
                    BASE_OCT: token_q = {token_q, $urandom_range(1) ? CH_UC_O : CH_LC_O};
                    default:  token_q = {token_q, $urandom_range(1) ? CH_UC_B : CH_LC_B};
                endcase
            end
            push_number(pick_magnitude(), b, upper);
            // Append a digit now and then, pushing a large value past 64 bits
            if ($urandom_range(99) < 12) token_q = {token_q, CH_ONE};
            if ($urandom_range(99) < 8)
                token_q.insert($urandom_range(token_q.size() - 1), pick_symbol());
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 4)) token_q = {token_q, pick_symbol()};
        end else begin
            repeat ($urandom_range(1, 6)) token_q = {token_q, 8'($urandom_range(255))};
        end
    endfunction

    task automatic test_random_tokens(int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars) begin
            build_token();
            foreach (token_q[i]) send_char(token_q[i], i == token_q.size() - 1);
            sent += token_q.size();
        end
    endtask

    // Sign only, bare prefixes and a lone zero all read as zero
    task automatic test_bare_tokens();
        send_text("0");
        send_text("-");
        send_text("0X");
        send_text("-0b");
        send_text("+0o");
    endtask

    // A separator before the prefix letter forces decimal
    task automatic test_separators();
        send_text("_0x1");
        send_text("0_1");
    endtask

    // Late sign, digit outside the base, and the byte extremes
    task automatic test_invalid_digits();
        send_text("1-");
        send_text("0o8");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Stall the result side for a long stretch while characters keep coming;
    // short tokens first so the result stage fills and the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_text("7");
        send_text("-8");
        send_text("0x9");
        send_text("10");
        send_text("+3");
        test_random_tokens(150);
    endtask

    // Let the pipeline run dry, then resume
    task automatic test_sender_pause();
        wait_results();
        test_random_tokens(100);
    endtask

    // Result side ready: random idling, or a counted hold-off on request
    initial begin : result_ready
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= !(idle_en && $urandom_range(99) < 6);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_int_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value_bits %h tuser %b", m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("value_bits: expected %h, got %h", want.value, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.is_uns) begin
                    $error("is_unsigned: expected %b, got %b", want.is_uns, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:1]);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing moves on either side for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_bare_tokens();
        test_separators();
        test_invalid_digits();
        wait_results();
        test_random_tokens(600);
        // Long stretch with both sides always ready
        idle_en = 1'b0;
        test_random_tokens(500);
        idle_en = 1'b1;
        test_backpressure();
        test_sender_pause();
        test_random_tokens(400);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
